>>> hw/rtl/ofa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ofa_pkg
// shared types, constants and rounding helper for the orthonormal frame block
// ---------------------------------------------------------------------------
package ofa_pkg;

    localparam logic signed [31:0] ONE_Q30    = 32'sh4000_0000;
    localparam logic        [31:0] NEAR_X_Q30 = 32'd966367642;
    localparam int                 NORM_LAT   = 68;

    typedef enum logic [0:0] {
        CFG_MIN_LENGTH = 1'b0,
        CFG_PAR_MARGIN = 1'b1
    } t_cfg_idx;

    typedef logic signed [32:0] t_vin;
    typedef logic signed [31:0] t_q30;

    typedef struct packed {
        logic signed [31:0] axis_z_x;
        logic signed [31:0] axis_z_y;
        logic signed [31:0] axis_z_z;
        logic signed [31:0] hint_x;
        logic signed [31:0] hint_y;
        logic signed [31:0] hint_z;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_x_x;
        logic signed [31:0] out_x_y;
        logic signed [31:0] out_x_z;
        logic signed [31:0] out_y_x;
        logic signed [31:0] out_y_y;
        logic signed [31:0] out_y_z;
        logic signed [31:0] out_z_x;
        logic signed [31:0] out_z_y;
        logic signed [31:0] out_z_z;
        logic               status;
    } t_out_word;

    // Q6.60 to Q6.30, half away from zero
    function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
        logic [65:0] m;
        logic [65:0] s;
        m = v[65] ? $unsigned(-v) : $unsigned(v);
        s = (m + 66'(1) * 66'd536870912) >> 30;
        rnd30 = v[65] ? -$signed(s[35:0]) : $signed(s[35:0]);
    endfunction

endpackage

>>> hw/rtl/ofa_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ofa_in_if
// input channel: axis and hint word with valid/ready
// ---------------------------------------------------------------------------
interface ofa_in_if import ofa_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/ofa_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ofa_out_if
// output channel: frame word with valid/ready
// ---------------------------------------------------------------------------
interface ofa_out_if import ofa_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/ofa_norm.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ofa_norm
// pipelined vector normalizer: squares, bitwise square root, three dividers
// ---------------------------------------------------------------------------
module ofa_norm import ofa_pkg::*; #(
    parameter int SBW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  t_vin           i_vec [3],
    input  logic [31:0]    i_thr,
    input  logic [SBW-1:0] i_sb,
    output logic           o_valid,
    output t_q30           o_vec [3],
    output logic           o_ok,
    output logic [SBW-1:0] o_sb
);

    localparam int CW = SBW + 3 + 96;

    logic [NORM_LAT-1:0] r_v;
    logic [CW-1:0]       r_cy   [0:34];
    logic [63:0]         r_sq   [3];
    logic [63:0]         r_rem  [0:32];
    logic [63:0]         r_root [0:32];
    logic [63:0]         r_dr   [0:31][3];
    logic [30:0]         r_dq   [0:31][3];
    logic [31:0]         r_ln   [0:31];
    logic                r_okk  [0:31];
    logic [SBW+2:0]      r_cz   [0:31];
    t_q30                r_out  [3];
    logic [31:0]         w_mag  [3];
    logic [31:0]         w_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NORM_LAT-2:0], i_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = i_vec[i][32] ? 32'($unsigned(-i_vec[i])) : 32'($unsigned(i_vec[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cy[0] <= {i_sb, i_vec[2][32], i_vec[1][32], i_vec[0][32],
                        w_mag[2], w_mag[1], w_mag[0]};
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= 64'(r_cy[0][32*i +: 32]) * 64'(r_cy[0][32*i +: 32]);
            end
            r_rem[0]  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_root[0] <= '0;
        end
    end

    for (genvar s = 1; s < 35; s++) begin : g_cy
        always_ff @(posedge i_clk) begin
            if (i_en) r_cy[s] <= r_cy[s-1];
        end
    end

    // one result bit per stage
    for (genvar k = 0; k < 32; k++) begin : g_sqrt
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[k] >= r_root[k] + BITV) begin
                    r_rem[k+1]  <= r_rem[k] - (r_root[k] + BITV);
                    r_root[k+1] <= (r_root[k] >> 1) + BITV;
                end else begin
                    r_rem[k+1]  <= r_rem[k];
                    r_root[k+1] <= r_root[k] >> 1;
                end
            end
        end
    end

    assign w_len = r_root[32][31:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ln[0]  <= w_len;
            r_okk[0] <= (w_len != 32'd0) && (w_len >= i_thr);
            r_cz[0]  <= r_cy[34][CW-1:96];
            for (int i = 0; i < 3; i++) begin
                r_dr[0][i] <= {2'b00, r_cy[34][32*i +: 32], 30'd0} + 64'(w_len >> 1);
                r_dq[0][i] <= '0;
            end
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < 31; j++) begin : g_div
        logic [63:0] w_dvs;
        assign w_dvs = 64'(r_ln[j]) << (30 - j);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ln[j+1]  <= r_ln[j];
                r_okk[j+1] <= r_okk[j];
                r_cz[j+1]  <= r_cz[j];
                for (int i = 0; i < 3; i++) begin
                    if (r_dr[j][i] >= w_dvs) begin
                        r_dr[j+1][i] <= r_dr[j][i] - w_dvs;
                        r_dq[j+1][i] <= {r_dq[j][i][29:0], 1'b1};
                    end else begin
                        r_dr[j+1][i] <= r_dr[j][i];
                        r_dq[j+1][i] <= {r_dq[j][i][29:0], 1'b0};
                    end
                end
            end
        end
    end

    logic r_ok_o;
    logic [SBW-1:0] r_sb_o;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= r_cz[31][i] ? -$signed({1'b0, r_dq[31][i]})
                                        :  $signed({1'b0, r_dq[31][i]});
            end
            r_ok_o <= r_okk[31];
            r_sb_o <= r_cz[31][SBW+2:3];
        end
    end

    assign o_valid = r_v[NORM_LAT-1];
    assign o_vec   = r_out;
    assign o_ok    = r_ok_o;
    assign o_sb    = r_sb_o;

endmodule

>>> hw/rtl/orthonormal_frame_from_axis_hint_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// orthonormal_frame_from_axis_hint_top
// right-handed orthonormal frame from a Z axis and an optional X hint
// ---------------------------------------------------------------------------
// i_in carries one Q16.16 Z axis and X hint per word; o_out returns the
// Q2.30 X, Y, Z axes and a status bit, one word out for every word in.
// i_cfg_we/i_cfg_idx/i_cfg_data write min_length and parallel_margin;
// write them only while no word is in flight.
// the path runs through four normalizers in series of 68 stages each (square,
// 32-stage square root, 31-stage divide), eight stages for the dot,
// rejection and cross products, and the output register.
// throughput is one word per cycle while the receiver takes words; every stage is a single register.
// the whole pipeline moves on one enable, which is high while the output
// register is empty or being taken; when the receiver stalls with a full
// output register every stage holds and i_in.ready drops.
// reset clears all valid bits and sets both registers to 1.
// ---------------------------------------------------------------------------
module orthonormal_frame_from_axis_hint_top import ofa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ofa_in_if.sink      i_in,
    ofa_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    logic [15:0] r_min_length;
    logic [30:0] r_par_margin;
    logic        w_en;
    logic [31:0] w_thr16;
    logic [31:0] w_thr30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= 16'd1;
            r_par_margin <= 31'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_LENGTH: r_min_length <= i_cfg_data[15:0];
                CFG_PAR_MARGIN: r_par_margin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_ov;
    t_out_word r_od;

    assign w_en       = !r_ov || o_out.ready;
    assign i_in.ready = w_en;
    assign w_thr16    = 32'(r_min_length);
    assign w_thr30    = {2'b00, r_min_length, 14'd0};

    // normalize Z and hint
    t_vin w_z_in [3];
    t_vin w_h_in [3];
    assign w_z_in[0] = 33'(i_in.data.axis_z_x);
    assign w_z_in[1] = 33'(i_in.data.axis_z_y);
    assign w_z_in[2] = 33'(i_in.data.axis_z_z);
    assign w_h_in[0] = 33'(i_in.data.hint_x);
    assign w_h_in[1] = 33'(i_in.data.hint_y);
    assign w_h_in[2] = 33'(i_in.data.hint_z);

    logic w_n1_v, w_n1h_v, w_zok, w_hok;
    t_q30 w_z1 [3];
    t_q30 w_h1 [3];
    logic w_sb_z, w_sb_h;

    ofa_norm #(.SBW(1)) u_norm_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(i_in.valid && w_en), .i_vec(w_z_in), .i_thr(w_thr16),
        .i_sb(1'b1), .o_valid(w_n1_v), .o_vec(w_z1), .o_ok(w_zok), .o_sb(w_sb_z)
    );

    ofa_norm #(.SBW(1)) u_norm_h (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(i_in.valid && w_en), .i_vec(w_h_in), .i_thr(w_thr16),
        .i_sb(1'b1), .o_valid(w_n1h_v), .o_vec(w_h1), .o_ok(w_hok), .o_sb(w_sb_h)
    );

    // dot, parallel test, rejection of the Z part
    logic [3:0]          r_b_v;
    logic signed [63:0]  r_b1_p [3];
    t_q30                r_b1_z [3];
    t_q30                r_b1_h [3];
    logic                r_b1_zok, r_b1_hok, r_b1_usex;
    t_q30                r_b2_z [3];
    t_q30                r_b2_h [3];
    logic signed [35:0]  r_b2_d, r_b2_dw;
    logic                r_b2_zok, r_b2_usex;
    t_q30                r_b3_z [3];
    t_q30                r_b3_h [3];
    logic signed [65:0]  r_b3_m [3];
    logic signed [65:0]  r_b3_mw [3];
    logic                r_b3_zok, r_b3_usex;
    t_q30                r_b4_z [3];
    t_vin                r_b4_r [3];
    t_vin                r_b4_rw [3];
    logic                r_b4_zok;

    logic signed [35:0] w_d, w_absd, w_thrp, w_dw;
    logic               w_pick;
    t_q30               w_hw1 [3];
    t_q30               w_hw3 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= '0;
        end else if (w_en) begin
            r_b_v <= {r_b_v[2:0], w_n1_v && w_n1h_v && w_sb_z && w_sb_h};
        end
    end

    always_comb begin
        w_d    = rnd30(66'(r_b1_p[0]) + 66'(r_b1_p[1]) + 66'(r_b1_p[2]));
        w_absd = w_d[35] ? -w_d : w_d;
        w_thrp = 36'(ONE_Q30) - $signed({5'd0, r_par_margin});
        w_pick = !r_b1_hok || (w_absd > w_thrp);
        w_dw   = r_b1_usex ? 36'(r_b1_z[0]) : 36'(r_b1_z[1]);
        w_hw1[0] = r_b1_usex ? ONE_Q30 : 32'sd0;
        w_hw1[1] = r_b1_usex ? 32'sd0 : ONE_Q30;
        w_hw1[2] = 32'sd0;
        w_hw3[0] = r_b3_usex ? ONE_Q30 : 32'sd0;
        w_hw3[1] = r_b3_usex ? 32'sd0 : ONE_Q30;
        w_hw3[2] = 32'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_b1_p[i] <= 64'(w_h1[i]) * 64'(w_z1[i]);
            end
            r_b1_z    <= w_z1;
            r_b1_h    <= w_h1;
            r_b1_zok  <= w_zok;
            r_b1_hok  <= w_hok;
            r_b1_usex <= (w_z1[0][31] ? 32'($unsigned(-w_z1[0])) : 32'($unsigned(w_z1[0])))
                         < NEAR_X_Q30;

            r_b2_z    <= r_b1_z;
            r_b2_h    <= w_pick ? w_hw1 : r_b1_h;
            r_b2_d    <= w_pick ? w_dw : w_d;
            r_b2_dw   <= w_dw;
            r_b2_zok  <= r_b1_zok;
            r_b2_usex <= r_b1_usex;

            for (int i = 0; i < 3; i++) begin
                r_b3_m[i]  <= 66'(r_b2_d) * 66'(r_b2_z[i]);
                r_b3_mw[i] <= 66'(r_b2_dw) * 66'(r_b2_z[i]);
            end
            r_b3_z    <= r_b2_z;
            r_b3_h    <= r_b2_h;
            r_b3_zok  <= r_b2_zok;
            r_b3_usex <= r_b2_usex;

            for (int i = 0; i < 3; i++) begin
                r_b4_r[i]  <= 33'(37'(r_b3_h[i]) - 37'(rnd30(r_b3_m[i])));
                r_b4_rw[i] <= 33'(37'(w_hw3[i]) - 37'(rnd30(r_b3_mw[i])));
            end
            r_b4_z   <= r_b3_z;
            r_b4_zok <= r_b3_zok;
        end
    end

    // normalize both rejection results
    logic        w_n2_v, w_n2w_v, w_rok, w_rwok;
    t_q30        w_hr [3];
    t_q30        w_hrw [3];
    logic [96:0] w_sb2, w_sb2w;

    ofa_norm #(.SBW(97)) u_norm_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(r_b_v[3]), .i_vec(r_b4_r), .i_thr(w_thr30),
        .i_sb({r_b4_zok, r_b4_z[2], r_b4_z[1], r_b4_z[0]}),
        .o_valid(w_n2_v), .o_vec(w_hr), .o_ok(w_rok), .o_sb(w_sb2)
    );

    ofa_norm #(.SBW(97)) u_norm_rw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(r_b_v[3]), .i_vec(r_b4_rw), .i_thr(w_thr30),
        .i_sb({r_b4_zok, r_b4_z[2], r_b4_z[1], r_b4_z[0]}),
        .o_valid(w_n2w_v), .o_vec(w_hrw), .o_ok(w_rwok), .o_sb(w_sb2w)
    );

    // Y = Z x X
    t_q30 w_z2 [3];
    t_q30 w_h2 [3];
    logic w_ok2;
    assign w_z2[0] = $signed(w_sb2[31:0]);
    assign w_z2[1] = $signed(w_sb2[63:32]);
    assign w_z2[2] = $signed(w_sb2[95:64]);
    assign w_ok2   = w_sb2[96] && w_sb2w[96] && (w_rok || w_rwok);
    always_comb begin
        for (int i = 0; i < 3; i++) w_h2[i] = w_rok ? w_hr[i] : w_hrw[i];
    end

    logic [1:0]         r_c_v;
    logic signed [63:0] r_c1_p [6];
    t_q30               r_c1_z [3];
    logic               r_c1_ok;
    t_vin               r_c2_y [3];
    t_q30               r_c2_z [3];
    logic               r_c2_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= '0;
        end else if (w_en) begin
            r_c_v <= {r_c_v[0], w_n2_v && w_n2w_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_p[0] <= 64'(w_z2[1]) * 64'(w_h2[2]);
            r_c1_p[1] <= 64'(w_z2[2]) * 64'(w_h2[1]);
            r_c1_p[2] <= 64'(w_z2[2]) * 64'(w_h2[0]);
            r_c1_p[3] <= 64'(w_z2[0]) * 64'(w_h2[2]);
            r_c1_p[4] <= 64'(w_z2[0]) * 64'(w_h2[1]);
            r_c1_p[5] <= 64'(w_z2[1]) * 64'(w_h2[0]);
            r_c1_z    <= w_z2;
            r_c1_ok   <= w_ok2;
            for (int i = 0; i < 3; i++) begin
                r_c2_y[i] <= 33'(rnd30(66'(r_c1_p[2*i]) - 66'(r_c1_p[2*i+1])));
            end
            r_c2_z  <= r_c1_z;
            r_c2_ok <= r_c1_ok;
        end
    end

    logic        w_n3_v, w_yok;
    t_q30        w_y3 [3];
    logic [96:0] w_sb3;

    ofa_norm #(.SBW(97)) u_norm_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(r_c_v[1]), .i_vec(r_c2_y), .i_thr(w_thr30),
        .i_sb({r_c2_ok, r_c2_z[2], r_c2_z[1], r_c2_z[0]}),
        .o_valid(w_n3_v), .o_vec(w_y3), .o_ok(w_yok), .o_sb(w_sb3)
    );

    // X = Y x Z
    t_q30 w_z3 [3];
    assign w_z3[0] = $signed(w_sb3[31:0]);
    assign w_z3[1] = $signed(w_sb3[63:32]);
    assign w_z3[2] = $signed(w_sb3[95:64]);

    logic [1:0]         r_d_v;
    logic signed [63:0] r_d1_p [6];
    t_q30               r_d1_y [3];
    t_q30               r_d1_z [3];
    logic               r_d1_ok;
    t_vin               r_d2_x [3];
    t_q30               r_d2_y [3];
    t_q30               r_d2_z [3];
    logic               r_d2_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= '0;
        end else if (w_en) begin
            r_d_v <= {r_d_v[0], w_n3_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_p[0] <= 64'(w_y3[1]) * 64'(w_z3[2]);
            r_d1_p[1] <= 64'(w_y3[2]) * 64'(w_z3[1]);
            r_d1_p[2] <= 64'(w_y3[2]) * 64'(w_z3[0]);
            r_d1_p[3] <= 64'(w_y3[0]) * 64'(w_z3[2]);
            r_d1_p[4] <= 64'(w_y3[0]) * 64'(w_z3[1]);
            r_d1_p[5] <= 64'(w_y3[1]) * 64'(w_z3[0]);
            r_d1_y    <= w_y3;
            r_d1_z    <= w_z3;
            r_d1_ok   <= w_sb3[96] && w_yok;
            for (int i = 0; i < 3; i++) begin
                r_d2_x[i] <= 33'(rnd30(66'(r_d1_p[2*i]) - 66'(r_d1_p[2*i+1])));
            end
            r_d2_y  <= r_d1_y;
            r_d2_z  <= r_d1_z;
            r_d2_ok <= r_d1_ok;
        end
    end

    logic         w_n4_v, w_xok;
    t_q30         w_x4 [3];
    logic [192:0] w_sb4;

    ofa_norm #(.SBW(193)) u_norm_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(r_d_v[1]), .i_vec(r_d2_x), .i_thr(w_thr30),
        .i_sb({r_d2_ok, r_d2_y[2], r_d2_y[1], r_d2_y[0],
               r_d2_z[2], r_d2_z[1], r_d2_z[0]}),
        .o_valid(w_n4_v), .o_vec(w_x4), .o_ok(w_xok), .o_sb(w_sb4)
    );

    // output register
    logic w_ok4;
    assign w_ok4 = w_sb4[192] && w_xok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_n4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_od.out_x_x <= w_ok4 ? w_x4[0] : 32'sd0;
            r_od.out_x_y <= w_ok4 ? w_x4[1] : 32'sd0;
            r_od.out_x_z <= w_ok4 ? w_x4[2] : 32'sd0;
            r_od.out_y_x <= w_ok4 ? $signed(w_sb4[127:96])  : 32'sd0;
            r_od.out_y_y <= w_ok4 ? $signed(w_sb4[159:128]) : 32'sd0;
            r_od.out_y_z <= w_ok4 ? $signed(w_sb4[191:160]) : 32'sd0;
            r_od.out_z_x <= w_ok4 ? $signed(w_sb4[31:0])    : 32'sd0;
            r_od.out_z_y <= w_ok4 ? $signed(w_sb4[63:32])   : 32'sd0;
            r_od.out_z_z <= w_ok4 ? $signed(w_sb4[95:64])   : 32'sd0;
            r_od.status  <= !w_ok4;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;

endmodule

>>> hw/rtl/ofa_chk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ofa_chk
// port-level checks for the orthonormal frame block
// ---------------------------------------------------------------------------
module ofa_chk import ofa_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output word changed while stalled");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status |->
            i_out_data.out_x_x == 0 && i_out_data.out_x_y == 0 && i_out_data.out_x_z == 0 &&
            i_out_data.out_y_x == 0 && i_out_data.out_y_y == 0 && i_out_data.out_y_z == 0 &&
            i_out_data.out_z_x == 0 && i_out_data.out_z_y == 0 && i_out_data.out_z_z == 0)
        else $error("degenerate frame with nonzero axes");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.status |->
            i_out_data.out_z_x <= ONE_Q30 && i_out_data.out_z_x >= -ONE_Q30 &&
            i_out_data.out_y_y <= ONE_Q30 && i_out_data.out_y_y >= -ONE_Q30 &&
            i_out_data.out_x_z <= ONE_Q30 && i_out_data.out_x_z >= -ONE_Q30)
        else $error("axis component out of unit range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind orthonormal_frame_from_axis_hint_top ofa_chk u_ofa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the orthonormal frame block
// ---------------------------------------------------------------------------
// words go in through a valid/ready source with random gaps and come back
// through a sink with random stalls. an in-bench fixed-point frame builder
// predicts every output word, and a checker compares it as a whole word.
// directed axes and hints come first, then random words over several
// register settings, idle phases and a long output hold-off.
// ---------------------------------------------------------------------------
module tb_top;
    import ofa_pkg::*;

    localparam int LATENCY = 281;
    localparam int LIMIT   = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    t_cfg_idx    i_cfg_idx = CFG_MIN_LENGTH;
    logic [30:0] i_cfg_data = '0;

    ofa_in_if  in_ch ();
    ofa_out_if out_ch ();

    orthonormal_frame_from_axis_hint_top i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_out_word frame_q[$];
    int        errors = 0;
    int        send_idle = 0;
    int        recv_stall = 0;
    int        hold_off = 0;
    longint    cycles = 0;
    longint    min_len = 1;
    longint    par_margin = 1;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        out_ch.ready = 1'b0;
    end

    // fixed-point frame builder
    function automatic longint round30(longint v);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (64'sd1 <<< 29)) >>> 30;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit unit3(input longint v[3], output longint o[3], input longint thr);
        logic [63:0] s;
        longint ln, m;
        logic [95:0] num;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m = v[i] < 0 ? -v[i] : v[i];
            s = s + 64'(m) * 64'(m);
        end
        ln = longint'(root_floor(s));
        if (ln == 0 || ln < thr) return 1'b0;
        for (int i = 0; i < 3; i++) begin
            m = v[i] < 0 ? -v[i] : v[i];
            num = ({32'd0, 64'(m)} << 30) + 96'(ln / 2);
            m = longint'(num / 96'(ln));
            o[i] = v[i] < 0 ? -m : m;
        end
        return 1'b1;
    endfunction

    function automatic longint dot3(longint a[3], longint b[3]);
        return round30(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint o[3]);
        o[0] = round30(a[1] * b[2] - a[2] * b[1]);
        o[1] = round30(a[2] * b[0] - a[0] * b[2]);
        o[2] = round30(a[0] * b[1] - a[1] * b[0]);
    endfunction

    function automatic void world_axis(input longint z[3], output longint h[3]);
        bit ux;
        ux = (z[0] < 0 ? -z[0] : z[0]) < longint'(NEAR_X_Q30);
        h[0] = ux ? 64'sd1 <<< 30 : 0;
        h[1] = ux ? 0 : 64'sd1 <<< 30;
        h[2] = 0;
    endfunction

    function automatic void drop_z(input longint h[3], input longint z[3],
                                   output longint r[3]);
        longint d;
        d = dot3(h, z);
        for (int i = 0; i < 3; i++) r[i] = h[i] - round30(d * z[i]);
    endfunction

    function automatic t_out_word frame_of(t_in_word w);
        longint zr[3], hr[3], z[3], h[3], r[3], yr[3], y[3], xr[3], x[3];
        longint thr, d;
        t_out_word o;
        bit ok;
        o = '0;
        thr = min_len <<< 14;
        zr = '{longint'(w.axis_z_x), longint'(w.axis_z_y), longint'(w.axis_z_z)};
        hr = '{longint'(w.hint_x), longint'(w.hint_y), longint'(w.hint_z)};
        ok = unit3(zr, z, min_len);
        if (ok) begin
            if (!unit3(hr, h, min_len)) begin
                world_axis(z, h);
            end else begin
                d = dot3(h, z);
                if ((d < 0 ? -d : d) > (64'sd1 <<< 30) - par_margin) world_axis(z, h);
            end
            drop_z(h, z, r);
            if (!unit3(r, h, thr)) begin
                world_axis(z, h);
                drop_z(h, z, r);
                ok = unit3(r, h, thr);
            end
        end
        if (ok) begin
            cross3(z, h, yr);
            ok = unit3(yr, y, thr);
        end
        if (ok) begin
            cross3(y, z, xr);
            ok = unit3(xr, x, thr);
        end
        if (!ok) begin
            o.status = 1'b1;
            return o;
        end
        o.out_x_x = 32'(x[0]); o.out_x_y = 32'(x[1]); o.out_x_z = 32'(x[2]);
        o.out_y_x = 32'(y[0]); o.out_y_y = 32'(y[1]); o.out_y_z = 32'(y[2]);
        o.out_z_x = 32'(z[0]); o.out_z_y = 32'(z[1]); o.out_z_z = 32'(z[2]);
        o.status = 1'b0;
        return o;
    endfunction

    task automatic send_word(t_in_word w);
        while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.data  = w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        frame_q.push_back(frame_of(w));
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (frame_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, longint val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= 31'(val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MIN_LENGTH) min_len = val & 16'hffff;
        else par_margin = val & 31'h7fffffff;
    endtask

    function automatic logic [31:0] rnd_comp();
        case ($urandom_range(4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2 * 65536 * 4)) - 65536 * 4);
            2: return 32'($signed($urandom_range(131072)) - 65536) <<< $urandom_range(15);
            3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return 32'($signed($urandom_range(20)) - 10);
        endcase
    endfunction

    function automatic t_in_word rnd_word();
        t_in_word w;
        w.axis_z_x = rnd_comp(); w.axis_z_y = rnd_comp(); w.axis_z_z = rnd_comp();
        case ($urandom_range(5))
            0: begin
                w.hint_x = 0; w.hint_y = 0; w.hint_z = 0;
            end
            1: begin
                // near parallel hint
                w.hint_x = w.axis_z_x + $signed($urandom_range(8)) - 4;
                w.hint_y = w.axis_z_y + $signed($urandom_range(8)) - 4;
                w.hint_z = w.axis_z_z;
            end
            default: begin
                w.hint_x = rnd_comp(); w.hint_y = rnd_comp(); w.hint_z = rnd_comp();
            end
        endcase
        return w;
    endfunction

    function automatic t_in_word mk(int zx, int zy, int zz, int hx, int hy, int hz);
        t_in_word w;
        w.axis_z_x = zx; w.axis_z_y = zy; w.axis_z_z = zz;
        w.hint_x = hx; w.hint_y = hy; w.hint_z = hz;
        return w;
    endfunction

    task automatic test_directed();
        localparam int ONE = 65536;
        send_word(mk(0, 0, ONE, ONE, 0, 0));
        send_word(mk(0, 0, ONE, 0, 0, 0));
        send_word(mk(ONE, 0, 0, 0, 0, 0));
        send_word(mk(0, 0, 0, ONE, 0, 0));
        send_word(mk(0, 0, ONE, 0, 0, 5 * ONE));
        send_word(mk(0, 0, ONE, 1, 0, ONE));
        send_word(mk(ONE, ONE, ONE, 0, ONE, 0));
        send_word(mk(-ONE, 0, 0, 0, -ONE, 0));
        send_word(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 0));
        send_word(mk(32'h80000000, 32'h80000000, 32'h80000000,
                     32'h7fffffff, 32'h80000000, 1));
        send_word(mk(1, 0, 0, 0, 1, 0));
        send_word(mk(-1, -1, -1, -1, -1, -1));
        send_word(mk(60000, 20000, 0, 0, ONE, 0));
        send_word(mk(0, 0, -ONE, 0, 0, -ONE));
        send_word(mk(ONE, 0, 0, ONE, 1, 0));
    endtask

    task automatic test_random(int n);
        repeat (n) send_word(rnd_word());
    endtask

    task automatic test_registers();
        write_reg(CFG_MIN_LENGTH, 0);
        write_reg(CFG_PAR_MARGIN, 0);
        test_directed();
        test_random(15);
        write_reg(CFG_MIN_LENGTH, 65535);
        write_reg(CFG_PAR_MARGIN, 31'h7fffffff);
        test_directed();
        test_random(10);
        write_reg(CFG_PAR_MARGIN, 1 << 30);
        write_reg(CFG_MIN_LENGTH, 100);
        test_random(10);
        write_reg(CFG_PAR_MARGIN, 5000000);
        write_reg(CFG_MIN_LENGTH, 1);
        test_random(15);
    endtask

    task automatic test_idling();
        send_idle = 47; recv_stall = 0; test_random(45);
        send_idle = 0; recv_stall = 47; test_random(45);
        send_idle = 7; recv_stall = 7; test_random(45);
        send_idle = 0; recv_stall = 0; test_random(15);
    endtask

    task automatic test_backpressure();
        hold_off = 600;
        test_random(290);
        drain();
        test_random(10);
    endtask

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            out_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            out_ch.ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
        end
    end

    always @(posedge i_clk) begin
        t_out_word exp_w;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (frame_q.size() == 0) begin
                $display("%0t unexpected word %h", $time, out_ch.data);
                errors++;
            end else begin
                exp_w = frame_q.pop_front();
                if (exp_w !== out_ch.data) begin
                    $display("%0t mismatch exp %h got %h", $time, exp_w, out_ch.data);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(20);
        test_registers();
        test_idling();
        test_backpressure();
        drain();
        if (errors == 0 && frame_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> orthonormal_frame_from_axis_hint_top.f
hw/rtl/ofa_pkg.sv
hw/rtl/ofa_in_if.sv
hw/rtl/ofa_out_if.sv
hw/rtl/ofa_norm.sv
hw/rtl/orthonormal_frame_from_axis_hint_top.sv
hw/rtl/ofa_chk.sv
tb/sv/tb_top.sv
